[hdl/union_find_with_move_assert.svh]
// assertion macros for the union_find_with_move block
// no dependencies; taken in by the files that carry checks
`ifndef UNION_FIND_WITH_MOVE_ASSERT_SVH
`define UNION_FIND_WITH_MOVE_ASSERT_SVH
`ifndef SYNTHESIS
`define UFWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ufwm check failed");
`define UFWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ufwm check failed");
`else
`define UFWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UFWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/ufwm_pkg.sv]
// shared types and constants for the union_find_with_move block
// no dependencies
package ufwm_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int TABLE_SIZE   = 2 * MAX_ELEMENTS + 2;
	localparam int IDX_W        = $clog2(TABLE_SIZE);
	localparam int CNT_W        = 11;
	localparam int SIZE_W       = 11;
	localparam int SUM_W        = 20;
	localparam int RESET_COUNT  = (1024 < MAX_ELEMENTS) ? 1024 : MAX_ELEMENTS;

	typedef enum logic [1:0] {
		FN_UNION = 2'd0,
		FN_MOVE  = 2'd1,
		FN_QUERY = 2'd2,
		FN_INIT  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND_P,
		ST_FIND_Q,
		ST_RD_A,
		ST_RD_B,
		ST_WR_B,
		ST_WR_A,
		ST_RES
	} state_t;

endpackage

[hdl/union_find_with_move.sv]
// union_find_with_move: disjoint-set table with union, move, query and rebuild
// depends on ufwm_pkg and union_find_with_move_assert.svh
`include "union_find_with_move_assert.svh"

// Disjoint-set table over elements 1..element_count, held in three synchronous
// memories (parent, size, sum) of 2*MAX_ELEMENTS+2 entries, each with separate
// read and write ports. After reset, and after an init command, a rebuild sweep
// writes every entry, one entry per cycle; no command is taken during it,
// configuration writes are. A find walks one parent link per cycle; an element
// under its own virtual root has a path of two nodes. A union or move of two
// elements already in one set writes nothing; an out-of-range union or move is
// dropped, and an out-of-range query returns an index error. The query result
// sits in an output register, so later commands are taken while it waits; a
// second query waits for it.
module union_find_with_move
	import ufwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [1:0]        func,
	input  logic [CNT_W-1:0]  first_element,
	input  logic [CNT_W-1:0]  second_element,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [SIZE_W-1:0] set_size,
	output logic [SUM_W-1:0]  set_sum,
	output logic              index_error
);

	// tables
	logic [IDX_W-1:0]  parent_mem [TABLE_SIZE];
	logic [SIZE_W-1:0] size_mem   [TABLE_SIZE];
	logic [SUM_W-1:0]  sum_mem    [TABLE_SIZE];

	state_t state_q, state_d;

	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  clr_n_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic              res_valid_q;

	logic [CNT_W-1:0]  p_q, q_q;
	logic [IDX_W-1:0]  cur_q, a_q, b_q, step_q;
	logic              is_query_q, is_move_q, err_q;
	logic [SIZE_W-1:0] size_a_q;
	logic [SUM_W-1:0]  sum_a_q;
	logic [SIZE_W-1:0] set_size_q;
	logic [SUM_W-1:0]  set_sum_q;
	logic              index_error_q;

	logic [IDX_W-1:0]  par_rd_q;
	logic [SIZE_W-1:0] size_rd_q;
	logic [SUM_W-1:0]  sum_rd_q;

	logic [IDX_W-1:0]  par_raddr, par_waddr, par_wdata;
	logic              par_we;
	logic [IDX_W-1:0]  ss_raddr, ss_waddr;
	logic              ss_we;
	logic [SIZE_W-1:0] size_wdata;
	logic [SUM_W-1:0]  sum_wdata;

	logic              cmd_xfer, p_ok, q_ok, res_load;
	logic              stop_walk, root_found;
	logic [IDX_W-1:0]  root_val;
	logic [IDX_W-1:0]  clr_n_ext, clr_par;
	logic              clr_lo, clr_hi;
	logic [SUM_W-1:0]  clr_sum;
	logic [CNT_W-1:0]  cfg_clamped;
	func_t             cmd_func;

	assign cmd_func  = func_t'(func);
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign p_ok      = (first_element != '0) && (first_element <= n_q);
	assign q_ok      = (second_element != '0) && (second_element <= n_q);
	assign res_load  = (state_q == ST_RES) && (!res_valid_q || res_ready);

	// one step of the parent walk
	assign stop_walk  = (par_rd_q == cur_q) || (par_rd_q >= IDX_W'(TABLE_SIZE));
	assign root_found = stop_walk || (step_q == IDX_W'(TABLE_SIZE - 1));
	assign root_val   = stop_walk ? cur_q : par_rd_q;

	// rebuild values for the entry under the sweep
	assign clr_n_ext = IDX_W'(clr_n_q);
	assign clr_lo    = (clr_idx_q != '0) && (clr_idx_q <= clr_n_ext);
	assign clr_hi    = (clr_idx_q > clr_n_ext) && (clr_idx_q <= (clr_n_ext << 1));
	assign clr_par   = clr_lo ? (clr_idx_q + clr_n_ext) : clr_idx_q;
	always_comb begin
		if (clr_lo) begin
			clr_sum = SUM_W'(clr_idx_q);
		end else if (clr_hi) begin
			clr_sum = SUM_W'(clr_idx_q - clr_n_ext);
		end else begin
			clr_sum = '0;
		end
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_clamped = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(MAX_ELEMENTS)) begin
			cfg_clamped = CNT_W'(MAX_ELEMENTS);
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == IDX_W'(TABLE_SIZE - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_func)
						FN_INIT:  state_d = ST_CLEAR;
						FN_QUERY: state_d = p_ok ? ST_FIND_P : ST_RES;
						default:  state_d = (p_ok && q_ok) ? ST_FIND_P : ST_IDLE;
					endcase
				end
			end
			ST_FIND_P: begin
				if (root_found) state_d = is_query_q ? ST_RD_A : ST_FIND_Q;
			end
			ST_FIND_Q: begin
				if (root_found) state_d = (root_val == a_q) ? ST_IDLE : ST_RD_A;
			end
			ST_RD_A: state_d = is_query_q ? ST_RES : ST_RD_B;
			ST_RD_B: state_d = ST_WR_B;
			ST_WR_B: state_d = is_move_q ? ST_WR_A : ST_IDLE;
			ST_WR_A: state_d = ST_IDLE;
			ST_RES: begin
				if (!res_valid_q || res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory addresses and writes
	always_comb begin
		par_raddr  = par_rd_q;
		par_we     = 1'b0;
		par_waddr  = a_q;
		par_wdata  = b_q;
		ss_raddr   = a_q;
		ss_we      = 1'b0;
		ss_waddr   = b_q;
		size_wdata = size_rd_q;
		sum_wdata  = sum_rd_q;
		unique case (state_q)
			ST_CLEAR: begin
				par_we     = 1'b1;
				par_waddr  = clr_idx_q;
				par_wdata  = clr_par;
				ss_we      = 1'b1;
				ss_waddr   = clr_idx_q;
				size_wdata = SIZE_W'(1);
				sum_wdata  = clr_sum;
			end
			ST_IDLE: par_raddr = IDX_W'(first_element);
			ST_FIND_P: begin
				if (root_found) par_raddr = IDX_W'(q_q);
			end
			ST_FIND_Q: par_raddr = par_rd_q;
			ST_RD_A, ST_RES: ss_raddr = a_q;
			ST_RD_B: ss_raddr = b_q;
			ST_WR_B: begin
				ss_we     = 1'b1;
				ss_waddr  = b_q;
				par_we    = 1'b1;
				par_waddr = is_move_q ? IDX_W'(p_q) : a_q;
				par_wdata = b_q;
				if (is_move_q) begin
					size_wdata = size_rd_q + SIZE_W'(1);
					sum_wdata  = sum_rd_q + SUM_W'(p_q);
				end else begin
					size_wdata = size_rd_q + size_a_q;
					sum_wdata  = sum_rd_q + sum_a_q;
				end
			end
			ST_WR_A: begin
				ss_we      = 1'b1;
				ss_waddr   = a_q;
				size_wdata = size_a_q - SIZE_W'(1);
				sum_wdata  = sum_a_q - SUM_W'(p_q);
			end
			default: par_raddr = par_rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we) parent_mem[par_waddr] <= par_wdata;
		par_rd_q <= parent_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (ss_we) begin
			size_mem[ss_waddr] <= size_wdata;
			sum_mem[ss_waddr]  <= sum_wdata;
		end
		size_rd_q <= size_mem[ss_raddr];
		sum_rd_q  <= sum_mem[ss_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			n_q         <= CNT_W'(RESET_COUNT);
			clr_n_q     <= CNT_W'(RESET_COUNT);
			clr_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) n_q <= cfg_clamped;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end else if (cmd_xfer && cmd_func == FN_INIT) begin
				clr_idx_q <= '0;
				clr_n_q   <= n_q;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// command and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					p_q        <= first_element;
					q_q        <= second_element;
					cur_q      <= IDX_W'(first_element);
					step_q     <= '0;
					is_query_q <= (cmd_func == FN_QUERY);
					is_move_q  <= (cmd_func == FN_MOVE);
					err_q      <= !p_ok;
				end
			end
			ST_FIND_P: begin
				if (root_found) begin
					a_q    <= root_val;
					cur_q  <= IDX_W'(q_q);
					step_q <= '0;
				end else begin
					cur_q  <= par_rd_q;
					step_q <= step_q + IDX_W'(1);
				end
			end
			ST_FIND_Q: begin
				if (root_found) begin
					b_q <= root_val;
				end else begin
					cur_q  <= par_rd_q;
					step_q <= step_q + IDX_W'(1);
				end
			end
			ST_RD_B: begin
				size_a_q <= size_rd_q;
				sum_a_q  <= sum_rd_q;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			set_size_q    <= err_q ? '0 : size_rd_q;
			set_sum_q     <= err_q ? '0 : sum_rd_q;
			index_error_q <= err_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign set_size    = set_size_q;
	assign set_sum     = set_sum_q;
	assign index_error = index_error_q;

	`UFWM_ASSERT_IMP(roots_differ_chk, clk, arst_n, state_q == ST_WR_B, a_q != b_q)
	`UFWM_ASSERT_IMP(err_zero_chk, clk, arst_n, res_valid && index_error, set_size == '0 && set_sum == '0)
	`UFWM_ASSERT_IMP(sweep_bound_chk, clk, arst_n, state_q == ST_CLEAR, clr_idx_q < IDX_W'(TABLE_SIZE))
	`UFWM_ASSERT_NXT(init_start_chk, clk, arst_n, cmd_xfer && cmd_func == FN_INIT, state_q == ST_CLEAR && clr_idx_q == '0)

endmodule
